@@ hw/rtl/trpi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpi_pkg: shared types and constants
// Payload structs, the front-to-back command and the sizes of the stores.
// ----------------------------------------------------------------------------
package trpi_pkg;

   localparam int DEF_MAX_NODES = 64;
   localparam int DEPTH         = 64;
   localparam int POS_W         = 6;
   localparam int CNT_W         = 7;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_MISSING  = 2'd2;

   typedef struct packed {
      logic [7:0] pre_symbol;
      logic [7:0] in_symbol;
      logic       last_pair;
   } req_type;

   typedef struct packed {
      logic [7:0] node_symbol;
      logic [1:0] status;
      logic       last_result;
   } rsp_type;

   // one classified item on its way from front to back
   typedef struct packed {
      logic [7:0]       pre_symbol;
      logic [7:0]       in_symbol;
      logic [POS_W-1:0] position;
      logic             store;
      logic             last;
      logic             overflow;
      logic [CNT_W-1:0] count;
   } cmd_type;

endpackage

@@ hw/rtl/trpi_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpi_front: input classifier
// Assigns each pair its position, tracks overflow and tags the last pair.
// ----------------------------------------------------------------------------
module trpi_front
   import trpi_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    push,
   output cmd_type push_cmd,
   input  logic    queue_full
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             store;

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;
   assign store     = count_ff < CNT_W'(MAX_NODES);

   always_comb begin
      push_cmd.pre_symbol = req_data.pre_symbol;
      push_cmd.in_symbol  = req_data.in_symbol;
      push_cmd.position   = count_ff[POS_W-1:0];
      push_cmd.store      = store;
      push_cmd.last       = req_data.last_pair;
      push_cmd.overflow   = ovf_ff | ~store;
      push_cmd.count      = store ? count_ff + 1'b1 : count_ff;
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (push) begin
         if (req_data.last_pair) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else if (store) begin
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

@@ hw/rtl/trpi_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpi_queue: command queue
// Short first-in first-out buffer between classifier and tree engine.
// ----------------------------------------------------------------------------
module trpi_queue
   import trpi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head_cmd
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   cmd_type         slot_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     fill_ff, fill_in;

   assign full      = fill_ff == (AW+1)'(QUEUE_DEPTH);
   assign not_empty = fill_ff != '0;
   assign head_cmd  = slot_ff[rd_ff];

   always_comb begin
      wr_in   = push ? wr_ff + 1'b1 : wr_ff;
      rd_in   = pop ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

@@ hw/rtl/trpi_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpi_back: tree engine
// Stores pairs, rebuilds the tree with a position stack, walks it in postorder.
// ----------------------------------------------------------------------------
module trpi_back
   import trpi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    not_empty,
   input  cmd_type head_cmd,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0_0000_0000_0001,
      S_PRE    = 13'b0_0000_0000_0010,
      S_PREW   = 13'b0_0000_0000_0100,
      S_SCAN   = 13'b0_0000_0000_1000,
      S_PLACE  = 13'b0_0000_0001_0000,
      S_POPW   = 13'b0_0000_0010_0000,
      S_LINK   = 13'b0_0000_0100_0000,
      S_WSTART = 13'b0_0000_1000_0000,
      S_WTOP   = 13'b0_0001_0000_0000,
      S_KIDR   = 13'b0_0010_0000_0000,
      S_KIDL   = 13'b0_0100_0000_0000,
      S_EMIT   = 13'b0_1000_0000_0000,
      S_ERR    = 13'b1_0000_0000_0000
   } state_type;

   // stores
   logic [7:0]       pre_mem   [DEPTH];
   logic [7:0]       in_mem    [DEPTH];
   logic [POS_W-1:0] left_mem  [DEPTH];
   logic [POS_W-1:0] right_mem [DEPTH];
   logic [CNT_W-1:0] stk_mem   [DEPTH];

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] n_ff, n_in, i_ff, i_in, sp_ff, sp_in, top_ff, top_in;
   logic [POS_W-1:0] k_ff, k_in, j_ff, j_in, popped_ff, popped_in, p_ff, p_in;
   logic [POS_W-1:0] root_ff, root_in;
   logic [1:0]       err_ff, err_in;
   logic [DEPTH-1:0] placed_ff, placed_in, lv_ff, lv_in, rv_ff, rv_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   // memory ports
   logic             pio_we, pre_re, in_re, lnk_re, l_we, r_we, s_we, s_re;
   logic [POS_W-1:0] pio_wa, pre_ra, in_ra, lnk_ra, l_wa, r_wa, s_wa, s_ra;
   logic [POS_W-1:0] l_wd, r_wd;
   logic [CNT_W-1:0] s_wd;
   logic [7:0]       pre_q, in_q;
   logic [POS_W-1:0] left_q, right_q;
   logic [CNT_W-1:0] stk_q;

   logic             out_free;
   logic [CNT_W-1:0] sp_dec;
   logic [POS_W-1:0] top_pos, stk_pos;

   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign sp_dec    = sp_ff - 1'b1;
   assign top_pos   = top_ff[POS_W-1:0];
   assign stk_pos   = stk_q[POS_W-1:0];

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      sp_in        = sp_ff;
      top_in       = top_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      popped_in    = popped_ff;
      p_in         = p_ff;
      root_in      = root_ff;
      err_in       = err_ff;
      placed_in    = placed_ff;
      lv_in        = lv_ff;
      rv_in        = rv_ff;
      out_valid_in = out_valid_ff & rsp_stall;
      out_in       = out_ff;
      pop          = 1'b0;
      pio_we       = 1'b0;
      pio_wa       = head_cmd.position;
      pre_re       = 1'b0;
      pre_ra       = i_ff[POS_W-1:0];
      in_re        = 1'b0;
      in_ra        = k_ff + 1'b1;
      lnk_re       = 1'b0;
      lnk_ra       = top_pos;
      l_we         = 1'b0;
      l_wa         = top_pos;
      l_wd         = j_ff;
      r_we         = 1'b0;
      r_wa         = popped_ff;
      r_wd         = j_ff;
      s_we         = 1'b0;
      s_wa         = sp_ff[POS_W-1:0];
      s_wd         = {1'b0, j_ff};
      s_re         = 1'b0;
      s_ra         = sp_dec[POS_W-1:0] - 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (not_empty) begin
               pop    = 1'b1;
               pio_we = head_cmd.store;
               if (head_cmd.last) begin
                  n_in = head_cmd.count;
                  if (head_cmd.overflow) begin
                     err_in   = ST_OVERFLOW;
                     state_in = S_ERR;
                  end else begin
                     i_in      = '0;
                     sp_in     = '0;
                     placed_in = '0;
                     lv_in     = '0;
                     rv_in     = '0;
                     state_in  = S_PRE;
                  end
               end
            end
         end
         S_PRE: begin
            pre_re   = 1'b1;
            state_in = S_PREW;
         end
         S_PREW: begin
            in_re    = 1'b1;
            in_ra    = '0;
            k_in     = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // in_q holds the inorder symbol at k_ff; next address already fetched
            in_re = 1'b1;
            k_in  = k_ff + 1'b1;
            if (in_q == pre_q) begin
               j_in     = k_ff;
               state_in = S_PLACE;
            end else if ({1'b0, k_ff} == n_ff - 1'b1) begin
               err_in   = ST_MISSING;
               state_in = S_ERR;
            end
         end
         S_PLACE: begin
            if (placed_ff[j_ff]) begin
               err_in   = ST_MISSING;
               state_in = S_ERR;
            end else begin
               placed_in[j_ff] = 1'b1;
               if (sp_ff == '0 || j_ff < top_pos) begin
                  if (sp_ff == '0) begin
                     root_in = j_ff;
                  end else begin
                     l_we         = 1'b1;
                     lv_in[top_pos] = 1'b1;
                  end
                  s_we   = 1'b1;
                  sp_in  = sp_ff + 1'b1;
                  top_in = {1'b0, j_ff};
                  i_in   = i_ff + 1'b1;
                  state_in = (i_ff + 1'b1 == n_ff) ? S_WSTART : S_PRE;
               end else begin
                  popped_in = top_pos;
                  sp_in     = sp_dec;
                  if (sp_dec != '0) begin
                     s_re     = 1'b1;
                     state_in = S_POPW;
                  end else begin
                     state_in = S_LINK;
                  end
               end
            end
         end
         S_POPW: begin
            if (j_ff > stk_pos) begin
               popped_in = stk_pos;
               sp_in     = sp_dec;
               if (sp_dec != '0) begin
                  s_re = 1'b1;
               end else begin
                  state_in = S_LINK;
               end
            end else begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            r_we             = 1'b1;
            rv_in[popped_ff] = 1'b1;
            s_we             = 1'b1;
            sp_in            = sp_ff + 1'b1;
            top_in           = {1'b0, j_ff};
            i_in             = i_ff + 1'b1;
            state_in         = (i_ff + 1'b1 == n_ff) ? S_WSTART : S_PRE;
         end
         S_WSTART: begin
            s_we     = 1'b1;
            s_wa     = '0;
            s_wd     = {1'b0, root_ff};
            sp_in    = CNT_W'(1);
            top_in   = {1'b0, root_ff};
            state_in = S_WTOP;
         end
         S_WTOP: begin
            if (top_ff[CNT_W-1]) begin
               // children done: fetch the symbol and the entry below
               in_re = 1'b1;
               in_ra = top_pos;
               sp_in = sp_dec;
               s_re  = sp_dec != '0;
               state_in = S_EMIT;
            end else begin
               s_we     = 1'b1;
               s_wa     = sp_dec[POS_W-1:0];
               s_wd     = {1'b1, top_pos};
               top_in   = {1'b1, top_pos};
               p_in     = top_pos;
               lnk_re   = 1'b1;
               state_in = S_KIDR;
            end
         end
         S_KIDR: begin
            if (rv_ff[p_ff]) begin
               s_we   = 1'b1;
               s_wd   = {1'b0, right_q};
               sp_in  = sp_ff + 1'b1;
               top_in = {1'b0, right_q};
            end
            state_in = S_KIDL;
         end
         S_KIDL: begin
            if (lv_ff[p_ff]) begin
               s_we   = 1'b1;
               s_wd   = {1'b0, left_q};
               sp_in  = sp_ff + 1'b1;
               top_in = {1'b0, left_q};
            end
            state_in = S_WTOP;
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_in.node_symbol = in_q;
               out_in.status      = ST_OK;
               out_in.last_result = sp_ff == '0;
               top_in             = stk_q;
               state_in           = (sp_ff == '0) ? S_IDLE : S_WTOP;
            end
         end
         S_ERR: begin
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_in.node_symbol = '0;
               out_in.status      = err_ff;
               out_in.last_result = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         sp_ff        <= '0;
         placed_ff    <= '0;
         lv_ff        <= '0;
         rv_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         sp_ff        <= sp_in;
         placed_ff    <= placed_in;
         lv_ff        <= lv_in;
         rv_ff        <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      i_ff      <= i_in;
      top_ff    <= top_in;
      k_ff      <= k_in;
      j_ff      <= j_in;
      popped_ff <= popped_in;
      p_ff      <= p_in;
      root_ff   <= root_in;
      err_ff    <= err_in;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (pio_we) begin
         pre_mem[pio_wa] <= head_cmd.pre_symbol;
         in_mem[pio_wa]  <= head_cmd.in_symbol;
      end
      if (pre_re) begin
         pre_q <= pre_mem[pre_ra];
      end
      if (in_re) begin
         in_q <= in_mem[in_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (l_we) begin
         left_mem[l_wa] <= l_wd;
      end
      if (r_we) begin
         right_mem[r_wa] <= r_wd;
      end
      if (lnk_re) begin
         left_q  <= left_mem[lnk_ra];
         right_q <= right_mem[lnk_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         stk_mem[s_wa] <= s_wd;
      end
      if (s_re) begin
         stk_q <= stk_mem[s_ra];
      end
   end

endmodule

@@ hw/rtl/tree_rebuild_preorder_inorder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_rebuild_preorder_inorder: binary tree rebuild, postorder output
// Rebuilds a tree from preorder/inorder pairs and emits nodes in postorder.
// ----------------------------------------------------------------------------
//  channel | direction | payload  | handshake
//  req_    | in        | req_type | req_valid / req_stall
//  rsp_    | out       | rsp_type | rsp_valid / rsp_stall
//
// Pairs enter one per cycle, unless the queue is full, into a 4-entry command
// queue; the idle engine stores one pair per cycle. On the last pair it scans
// inorder memory once per preorder symbol (one memory read per cycle), then
// walks the tree in postorder. Reset is synchronous; after it the block is
// empty. A stalled result holds the engine; the queue takes pairs until full.
module tree_rebuild_preorder_inorder
   import trpi_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    push, full, pop, not_empty;
   cmd_type push_cmd, head_cmd;

   trpi_front #(.MAX_NODES(MAX_NODES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (full)
   );

   trpi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_cmd  (head_cmd)
   );

   trpi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head_cmd  (head_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hw/rtl/trpi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpi_checker: port checks
// Watches the result channel of the tree rebuild block.
// ----------------------------------------------------------------------------
module trpi_checker
   import trpi_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_OVERFLOW
                     || rsp_data.status == ST_MISSING))
      else $error("bad status code");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.last_result && rsp_data.node_symbol == 8'd0)
      else $error("error item not a single final item");

   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled item changed");

endmodule

bind tree_rebuild_preorder_inorder trpi_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
